// ----- sv/abps3_pkg.sv -----
// ----------------------------------------------------------------------------
// abps3_pkg
// shared constants and codes for the swept 3d aabb broad phase
// ----------------------------------------------------------------------------
package abps3_pkg;

  localparam int MAX_BODIES_DEF = 16;
  localparam int COORD_BITS_DEF = 32;
  localparam int MAX_RESULTS    = 15;
  localparam int RES_W          = $clog2(MAX_RESULTS + 1);

  localparam int FIELD_W  = 32;
  localparam int INDEX_W  = 4;
  localparam int MODE_W   = 3;
  localparam int CMD_W    = 2;
  localparam int DT_W     = 21;
  localparam int IN_DATA_W  = 296;
  localparam int OUT_DATA_W = 8;

  localparam logic [DT_W-1:0] TIME_STEP_RESET = 21'd1092;
  localparam logic signed [FIELD_W:0] HALF_ONE = 33'sd32768;

  localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd0;
  localparam logic [CMD_W-1:0] CMD_LOAD  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_QUERY = 2'd2;

  localparam logic [1:0] SHAPE_BOX    = 2'd1;
  localparam logic [1:0] SHAPE_SPHERE = 2'd2;

endpackage

// ----- sv/aabb_broad_phase_3d_swept.sv -----
// ----------------------------------------------------------------------------
// aabb_broad_phase_3d_swept
// box list with load, clear and pairwise overlap query, boxes held in one ram
// ----------------------------------------------------------------------------
// input channel s_*: tuser carries the command, tdata the body fields.
// a clear or an unknown command is taken without leaving idle. a load
// registers the half extents and the velocity sweep product as it is
// taken; the S_LWR state then saturates the bounds and writes the box ram
// at the list tail, and a load into a full list is dropped. a query reads
// the queried box, then walks the ram one stored box per cycle from
// index+1 to the list end; the ram read port sets this pace. the final
// transfer is loaded in S_FLUSH, which a query of a body not in the list
// enters straight from idle. one result is held back so the last one can
// be marked with m_tlast; at most 15 pairs are reported. a query with no
// pair gives one transfer with m_tuser low. output channel m_*: the result
// register holds a transfer until taken; while it is full and another pair
// must be pushed the walk pauses on the same entry. s_tready is high only
// between items. reset empties the list, sets time_step to 1092 and drops
// m_tvalid; the box ram itself is not cleared.
// ----------------------------------------------------------------------------
module aabb_broad_phase_3d_swept
  import abps3_pkg::*;
#(
  parameter int MAX_BODIES = MAX_BODIES_DEF,
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [DT_W-1:0]       cfg_wdata,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  // body_index, pos_x, pos_y, pos_z, vel_x, vel_y, vel_z, size_x, size_y,
  // size_z, collider_mode, one zero pad bit
  input  logic [IN_DATA_W-1:0]  s_tdata,
  // cmd
  input  logic [CMD_W-1:0]      s_tuser,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  // first_index, second_index
  output logic [OUT_DATA_W-1:0] m_tdata,
  // pair_valid
  output logic                  m_tuser,
  output logic                  m_tlast
);

  localparam int IDX_W = (MAX_BODIES > 1) ? $clog2(MAX_BODIES) : 1;
  localparam int CNT_W = $clog2(MAX_BODIES + 1);
  localparam int QW    = (CNT_W > INDEX_W) ? CNT_W : INDEX_W;
  localparam int SW_W  = 2 * FIELD_W - 16 + DT_W - FIELD_W + 1;
  localparam int SUM_W = (COORD_BITS + 1 > 40) ? COORD_BITS + 1 : 40;
  localparam logic signed [63:0] SAT_HI64 = (64'sd1 <<< (COORD_BITS - 1)) - 64'sd1;
  localparam logic signed [SUM_W-1:0] SAT_HI = SUM_W'(SAT_HI64);
  localparam logic signed [SUM_W-1:0] SAT_LO = SUM_W'(-SAT_HI64 - 64'sd1);

  typedef struct packed {
    logic signed [COORD_BITS-1:0] min_x;
    logic signed [COORD_BITS-1:0] min_y;
    logic signed [COORD_BITS-1:0] min_z;
    logic signed [COORD_BITS-1:0] max_x;
    logic signed [COORD_BITS-1:0] max_y;
    logic signed [COORD_BITS-1:0] max_z;
  } box_t;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_LWR   = 5'b00010,
    S_QBOX  = 5'b00100,
    S_SCAN  = 5'b01000,
    S_FLUSH = 5'b10000
  } state_t;

  state_t            state;
  state_t            state_next;
  logic [DT_W-1:0]   time_step;
  logic [CNT_W-1:0]  body_count;
  box_t              box_mem [MAX_BODIES];
  box_t              rd_data;
  logic [IDX_W-1:0]  rd_addr;
  box_t              qbox;
  box_t              wr_box;
  logic [QW-1:0]     q_idx;
  logic [CNT_W-1:0]  j_idx;
  logic [CNT_W-1:0]  j_step;
  logic              pend_valid;
  logic [CNT_W-1:0]  pend_j;
  logic [RES_W-1:0]  n_found;

  // load stage
  logic signed [FIELD_W:0]   ld_lo [3];
  logic signed [FIELD_W:0]   ld_hi [3];
  logic signed [SW_W-1:0]    ld_d  [3];
  logic                      ld_cont;
  logic signed [FIELD_W-1:0] in_pos  [3];
  logic signed [FIELD_W-1:0] in_vel  [3];
  logic signed [FIELD_W-1:0] in_size [3];
  logic signed [FIELD_W:0]   half    [3];
  logic signed [FIELD_W:0]   lo_c    [3];
  logic signed [FIELD_W:0]   hi_c    [3];
  logic signed [FIELD_W+DT_W:0] vel_dt [3];
  logic signed [SW_W-1:0]    d_c     [3];
  logic signed [COORD_BITS-1:0] bmin [3];
  logic signed [COORD_BITS-1:0] bmax [3];
  logic signed [FIELD_W:0]   radius;
  logic [1:0]                shape;

  logic s_fire;
  logic push_ok;
  logic overlap;
  logic scan_stall;
  logic scan_push;
  logic q_in_list;

  function automatic logic signed [COORD_BITS-1:0] sat_coord(
    input logic signed [SUM_W-1:0] v
  );
    logic signed [SUM_W-1:0] c;
    c = v;
    if (v > SAT_HI) c = SAT_HI;
    else if (v < SAT_LO) c = SAT_LO;
    return c[COORD_BITS-1:0];
  endfunction

  assign s_tready = (state == S_IDLE);
  assign s_fire   = s_tvalid && s_tready;
  assign push_ok  = !m_tvalid || m_tready;
  assign j_step   = j_idx + CNT_W'(1);
  assign q_in_list = QW'(INDEX_W'(s_tdata[3:0])) < QW'(body_count);

  // body fields
  always_comb begin
    for (int a = 0; a < 3; a++) begin
      in_pos[a]  = s_tdata[4 + FIELD_W * a +: FIELD_W];
      in_vel[a]  = s_tdata[4 + FIELD_W * (a + 3) +: FIELD_W];
      in_size[a] = s_tdata[4 + FIELD_W * (a + 6) +: FIELD_W];
    end
    shape  = s_tdata[4 + FIELD_W * 9 + 1 +: 2];
    radius = (FIELD_W + 1)'(in_size[0]) >>> 1;
    for (int a = 0; a < 3; a++) begin
      half[a] = HALF_ONE;
      if (shape == SHAPE_BOX) begin
        half[a] = (FIELD_W + 1)'(in_size[a]) >>> 1;
      end else if (shape == SHAPE_SPHERE && radius > 0) begin
        half[a] = radius;
      end
      lo_c[a] = (FIELD_W + 1)'(in_pos[a]) - half[a];
      hi_c[a] = (FIELD_W + 1)'(in_pos[a]) + half[a];
      vel_dt[a] = in_vel[a] * $signed({1'b0, time_step});
      d_c[a]  = SW_W'(vel_dt[a] >>> 16);
    end
  end

  // bound saturation for the ram write
  always_comb begin
    logic signed [SUM_W-1:0] lo_e;
    logic signed [SUM_W-1:0] hi_e;
    logic signed [SUM_W-1:0] lo_s;
    logic signed [SUM_W-1:0] hi_s;
    for (int a = 0; a < 3; a++) begin
      lo_e = SUM_W'(ld_lo[a]);
      hi_e = SUM_W'(ld_hi[a]);
      lo_s = lo_e + SUM_W'(ld_d[a]);
      hi_s = hi_e + SUM_W'(ld_d[a]);
      if (ld_cont && lo_s < lo_e) lo_e = lo_s;
      if (ld_cont && hi_s > hi_e) hi_e = hi_s;
      bmin[a] = sat_coord(lo_e);
      bmax[a] = sat_coord(hi_e);
    end
    wr_box = '{min_x: bmin[0], min_y: bmin[1], min_z: bmin[2],
               max_x: bmax[0], max_y: bmax[1], max_z: bmax[2]};
  end

  assign overlap = !(qbox.max_x < rd_data.min_x || rd_data.max_x < qbox.min_x) &&
                   !(qbox.max_y < rd_data.min_y || rd_data.max_y < qbox.min_y) &&
                   !(qbox.max_z < rd_data.min_z || rd_data.max_z < qbox.min_z);
  assign scan_stall = (state == S_SCAN) && overlap && pend_valid && !push_ok;
  assign scan_push  = (state == S_SCAN) && overlap && !scan_stall;

  always_comb begin
    state_next = state;
    rd_addr    = j_idx[IDX_W-1:0];
    unique case (state)
      S_IDLE: begin
        rd_addr = IDX_W'(INDEX_W'(s_tdata[3:0]));
        if (s_fire) begin
          unique case (s_tuser)
            CMD_LOAD: begin
              if (body_count < CNT_W'(MAX_BODIES)) state_next = S_LWR;
            end
            CMD_QUERY: state_next = q_in_list ? S_QBOX : S_FLUSH;
            default: state_next = S_IDLE;
          endcase
        end
      end
      S_LWR: state_next = S_IDLE;
      S_QBOX: begin
        rd_addr = IDX_W'(q_idx + QW'(1));
        state_next = (CNT_W'(q_idx + QW'(1)) >= body_count) ? S_FLUSH : S_SCAN;
      end
      S_SCAN: begin
        rd_addr = scan_stall ? j_idx[IDX_W-1:0] : IDX_W'(j_step);
        if (!scan_stall) begin
          if ((scan_push && n_found == RES_W'(MAX_RESULTS - 1)) || j_step >= body_count) begin
            state_next = S_FLUSH;
          end
        end
      end
      S_FLUSH: begin
        if (push_ok) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    rd_data <= box_mem[rd_addr];
    if (state == S_LWR) begin
      box_mem[body_count[IDX_W-1:0]] <= wr_box;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      time_step  <= TIME_STEP_RESET;
      body_count <= '0;
      pend_valid <= 1'b0;
      n_found    <= '0;
      m_tvalid   <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_we) time_step <= cfg_wdata;

      if ((scan_push && pend_valid) || (state == S_FLUSH && push_ok)) begin
        m_tvalid <= 1'b1;
      end else if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end

      if (s_fire && s_tuser == CMD_CLEAR) body_count <= '0;
      if (state == S_LWR) body_count <= body_count + CNT_W'(1);

      if (s_fire) begin
        pend_valid <= 1'b0;
        n_found    <= '0;
      end

      if (scan_push) begin
        pend_valid <= 1'b1;
        n_found    <= n_found + RES_W'(1);
      end

      if (state == S_FLUSH && push_ok) begin
        pend_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_fire) begin
      q_idx   <= QW'(INDEX_W'(s_tdata[3:0]));
      ld_cont <= s_tdata[4 + FIELD_W * 9];
      for (int a = 0; a < 3; a++) begin
        ld_lo[a] <= lo_c[a];
        ld_hi[a] <= hi_c[a];
        ld_d[a]  <= d_c[a];
      end
    end
    if (state == S_QBOX) begin
      qbox  <= rd_data;
      j_idx <= CNT_W'(q_idx + QW'(1));
    end
    if (state == S_SCAN && !scan_stall) j_idx <= j_step;
    if (scan_push) begin
      pend_j <= j_idx;
      if (pend_valid) begin
        m_tuser <= 1'b1;
        m_tdata <= {INDEX_W'(pend_j), INDEX_W'(q_idx)};
        m_tlast <= 1'b0;
      end
    end
    if (state == S_FLUSH && push_ok) begin
      m_tuser <= pend_valid;
      m_tdata <= {pend_valid ? INDEX_W'(pend_j) : INDEX_W'(0), INDEX_W'(q_idx)};
      m_tlast <= 1'b1;
    end
  end

  a_idle_no_pending: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> !pend_valid)
    else $error("pending pair left over between items");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    body_count <= CNT_W'(MAX_BODIES))
    else $error("body count beyond list size");

  a_scan_in_list: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN) |-> (j_idx < body_count && CNT_W'(q_idx) < j_idx))
    else $error("scan index outside the walked range");

  a_result_cap: assert property (@(posedge clk) disable iff (rst)
    n_found <= RES_W'(MAX_RESULTS))
    else $error("too many pairs found");

endmodule

// ----- sim/tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Stream test of the swept 3d aabb broad phase. A directed table covers the
// collider shapes, sweep saturation, touching boxes, the full list, clear and
// the no-pair answer. Random clear/load/query runs follow, for several frame
// times. Every transfer on the result side is checked against a predictor
// that rebuilds the box list on its own, or against a directed row's pair.
// ----------------------------------------------------------------------------
module tb;
  import abps3_pkg::*;

  localparam logic [CMD_W-1:0]  CMD_UNUSED        = 2'd3;
  localparam logic [MODE_W-1:0] MODE_DEFAULT      = 3'd0;
  localparam logic [MODE_W-1:0] MODE_DEFAULT_SWEPT = 3'd1;
  localparam logic [MODE_W-1:0] MODE_BOX          = {SHAPE_BOX, 1'b0};
  localparam logic [MODE_W-1:0] MODE_BOX_SWEPT    = {SHAPE_BOX, 1'b1};
  localparam logic [MODE_W-1:0] MODE_SPHERE       = {SHAPE_SPHERE, 1'b0};
  localparam logic [MODE_W-1:0] MODE_SPHERE_SWEPT = {SHAPE_SPHERE, 1'b1};
  localparam logic [MODE_W-1:0] MODE_SHAPE3       = 3'd6;
  localparam logic [MODE_W-1:0] MODE_SHAPE3_SWEPT = 3'd7;
  localparam int unsigned RUN_LIMIT = 500000;
  localparam int SETTLE_CYCLES = 8;

  typedef struct {
    logic [CMD_W-1:0]          cmd;
    logic [INDEX_W-1:0]        idx;
    logic signed [FIELD_W-1:0] pos[3];
    logic signed [FIELD_W-1:0] vel[3];
    logic signed [FIELD_W-1:0] size[3];
    logic [MODE_W-1:0]         mode;
  } body_item_t;

  typedef struct packed {
    logic               pair_valid;
    logic [INDEX_W-1:0] first_index;
    logic [INDEX_W-1:0] second_index;
    logic               last;
  } pair_t;

  typedef struct {
    body_item_t item;
    bit         typed;
    pair_t      want;
  } directed_row_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_we = 1'b0;
  logic [DT_W-1:0]       cfg_wdata = '0;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  // body_index, pos_x, pos_y, pos_z, vel_x, vel_y, vel_z, size_x, size_y,
  // size_z, collider_mode, zero pad
  logic [IN_DATA_W-1:0]  s_tdata = '0;
  // cmd
  logic [CMD_W-1:0]      s_tuser = '0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b1;
  // first_index, second_index
  logic [OUT_DATA_W-1:0] m_tdata;
  // pair_valid
  logic                  m_tuser;
  logic                  m_tlast;

  aabb_broad_phase_3d_swept u_top (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  always #2 clk = ~clk;

  // predictor state
  logic [DT_W-1:0] frame_dt = TIME_STEP_RESET;
  int unsigned     list_len = 0;
  int unsigned     written_hi = 0;
  longint          box_lo[MAX_BODIES_DEF][3];
  longint          box_hi[MAX_BODIES_DEF][3];
  pair_t           pred_pairs[$];
  pair_t           pending_pairs[$];

  int          errors = 0;
  int unsigned stim_count = 0;
  int unsigned cycle_count = 0;
  bit          idle_on = 1'b1;
  directed_row_t directed[$];
  pair_t       got_pair;
  pair_t       want_pair;

  function automatic longint sat_coord(longint v);
    longint hi_lim;
    longint lo_lim;
    hi_lim = (longint'(1) <<< (COORD_BITS_DEF - 1)) - 1;
    lo_lim = -hi_lim - 1;
    return (v > hi_lim) ? hi_lim : ((v < lo_lim) ? lo_lim : v);
  endfunction

  // updates the box list and fills pred_pairs; returns 0 when the item is ignored
  function automatic bit apply_item(body_item_t it);
    longint     half[3];
    longint     lo;
    longint     hi;
    longint     d;
    longint     r;
    bit         sweep;
    bit         hit;
    logic [1:0] shape;
    pred_pairs.delete();
    case (it.cmd)
      CMD_CLEAR: begin
        list_len = 0;
        return 1'b1;
      end
      CMD_LOAD: begin
        if (list_len >= MAX_BODIES_DEF) return 1'b0;
        shape = it.mode[2:1];
        sweep = it.mode[0];
        for (int a = 0; a < 3; a++) half[a] = longint'(HALF_ONE);
        if (shape == SHAPE_BOX) begin
          for (int a = 0; a < 3; a++) half[a] = longint'(it.size[a]) >>> 1;
        end else if (shape == SHAPE_SPHERE) begin
          r = longint'(it.size[0]) >>> 1;
          if (r > 0) for (int a = 0; a < 3; a++) half[a] = r;
        end
        for (int a = 0; a < 3; a++) begin
          lo = longint'(it.pos[a]) - half[a];
          hi = longint'(it.pos[a]) + half[a];
          if (sweep) begin
            d = (longint'(it.vel[a]) * longint'(frame_dt)) >>> 16;
            if (d < 0) lo = lo + d;
            else hi = hi + d;
          end
          box_lo[list_len][a] = sat_coord(lo);
          box_hi[list_len][a] = sat_coord(hi);
        end
        list_len++;
        if (list_len > written_hi) written_hi = list_len;
        return 1'b1;
      end
      CMD_QUERY: begin
        if (it.idx < list_len) begin
          for (int j = int'(it.idx) + 1; j < list_len && pred_pairs.size() < MAX_RESULTS; j++) begin
            hit = 1'b1;
            for (int a = 0; a < 3; a++)
              if (box_hi[it.idx][a] < box_lo[j][a] || box_hi[j][a] < box_lo[it.idx][a])
                hit = 1'b0;
            if (hit) pred_pairs.insert(pred_pairs.size(), '{1'b1, it.idx, INDEX_W'(j), 1'b0});
          end
        end
        if (pred_pairs.size() == 0) pred_pairs.insert(0, '{1'b0, it.idx, '0, 1'b1});
        else pred_pairs[pred_pairs.size() - 1].last = 1'b1;
        return 1'b1;
      end
      default: return 1'b0;
    endcase
  endfunction

  function automatic body_item_t load_item(int px, int py, int pz, int vx, int vy, int vz,
                                           int sx, int sy, int sz, logic [MODE_W-1:0] mode);
    body_item_t it;
    it.cmd = CMD_LOAD;
    it.idx = '0;
    it.pos[0] = px;  it.pos[1] = py;  it.pos[2] = pz;
    it.vel[0] = vx;  it.vel[1] = vy;  it.vel[2] = vz;
    it.size[0] = sx; it.size[1] = sy; it.size[2] = sz;
    it.mode = mode;
    return it;
  endfunction

  function automatic body_item_t ctl_item(logic [CMD_W-1:0] cmd, logic [INDEX_W-1:0] idx);
    body_item_t it;
    it = load_item(0, 0, 0, 0, 0, 0, 0, 0, 0, MODE_DEFAULT);
    it.cmd = cmd;
    it.idx = idx;
    return it;
  endfunction

  function automatic body_item_t rand_load(bit clustered);
    body_item_t it;
    it = load_item(0, 0, 0, 0, 0, 0, 0, 0, 0, MODE_DEFAULT);
    for (int a = 0; a < 3; a++) begin
      if (clustered) begin
        it.pos[a]  = $urandom_range(0, 32'h40000) - 32'h20000;
        it.vel[a]  = $urandom_range(0, 32'h200000) - 32'h100000;
        it.size[a] = $urandom_range(0, 32'h48000) - 32'h8000;
      end else begin
        it.pos[a]  = $urandom;
        it.vel[a]  = $urandom;
        it.size[a] = $urandom;
      end
    end
    it.idx  = INDEX_W'($urandom_range(0, 15));
    it.mode = MODE_W'($urandom_range(0, 7));
    return it;
  endfunction

  task automatic send_item(body_item_t it, bit typed, pair_t want);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= it.cmd;
    s_tdata  <= {1'b0, it.mode, it.size[2], it.size[1], it.size[0],
                 it.vel[2], it.vel[1], it.vel[0], it.pos[2], it.pos[1], it.pos[0], it.idx};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    void'(apply_item(it));
    stim_count++;
    if (typed) pending_pairs.insert(pending_pairs.size(), want);
    else foreach (pred_pairs[i]) pending_pairs.insert(pending_pairs.size(), pred_pairs[i]);
  endtask

  task automatic set_time_step(logic [DT_W-1:0] value);
    s_tvalid <= 1'b0;
    while (pending_pairs.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we   <= 1'b0;
    frame_dt = value;
  endtask

  // an optional clear, a run of loads, then queries mostly into the list
  task automatic run_burst(bit quiet);
    int  n_loads;
    int  n_queries;
    bit  clustered;
    body_item_t it;
    if (!quiet) idle_on = ($urandom_range(0, 2) != 0);
    clustered = ($urandom_range(0, 3) != 0);
    n_loads = ($urandom_range(0, 5) == 0) ? $urandom_range(12, 18) : $urandom_range(1, 6);
    n_queries = $urandom_range(1, 4);
    if ($urandom_range(0, 4) != 0)
      send_item(ctl_item(CMD_CLEAR, INDEX_W'($urandom_range(0, 15))), 0, '0);
    for (int k = 0; k < n_loads; k++) send_item(rand_load(clustered), 0, '0);
    for (int k = 0; k < n_queries; k++) begin
      it = rand_load(1'b0);
      it.cmd = CMD_QUERY;
      if (list_len > 0 && $urandom_range(0, 4) != 0)
        it.idx = INDEX_W'($urandom_range(0, list_len - 1));
      else if (written_hi > 0) it.idx = INDEX_W'($urandom_range(0, written_hi - 1));
      else it.cmd = CMD_LOAD;
      send_item(it, 0, '0);
    end
    if ($urandom_range(0, 7) == 0) begin
      it = rand_load(1'b0);
      it.cmd = CMD_UNUSED;
      send_item(it, 0, '0);
    end
  endtask

  task automatic check_field(string what, int unsigned want, int unsigned got);
    if (want != got) begin
      errors++;
      $display("%0t %s expected %0d actual %0d", $time, what, want, got);
    end
  endtask

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      got_pair = {m_tuser, m_tdata[3:0], m_tdata[7:4], m_tlast};
      if (pending_pairs.size() == 0) begin
        errors++;
        $display("%0t unexpected transfer expected none actual %h", $time, got_pair);
      end else begin
        want_pair = pending_pairs.pop_front();
        check_field("pair_valid", 32'(want_pair.pair_valid), 32'(got_pair.pair_valid));
        check_field("first_index", 32'(want_pair.first_index), 32'(got_pair.first_index));
        check_field("second_index", 32'(want_pair.second_index), 32'(got_pair.second_index));
        check_field("last", 32'(want_pair.last), 32'(got_pair.last));
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == RUN_LIMIT) begin
      $display("FAIL aabb_broad_phase_3d_swept");
      $finish;
    end
  end

  initial begin
    forever begin
      @(posedge clk);
      if (idle_on && $urandom_range(0, 5) == 0) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 7)) @(posedge clk);
        m_tready <= 1'b1;
      end
    end
  end

  initial begin
    logic [DT_W-1:0] dt_plan[5];
    int unsigned target;
    dt_plan = '{21'd0, 21'h1FFFFF, 21'd1048576, 21'd0, TIME_STEP_RESET};
    dt_plan[3] = DT_W'($urandom_range(1, 21'h1FFFFF));

    // fill the list with every shape, sweep and saturation corner
    directed.push_back('{load_item(0, 0, 0, 0, 0, 0, 0, 0, 0, MODE_DEFAULT), 0, '0});
    directed.push_back('{load_item(32'h10000, 0, 0, 0, 0, 0, 32'h10000, 32'h10000,
                                   32'h10000, MODE_BOX), 0, '0});
    directed.push_back('{load_item(0, 0, 0, 0, 0, 0, 32'h7FFFFFFF, 0, 0, MODE_SPHERE), 0, '0});
    directed.push_back('{load_item(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 0, 0, 0,
                                   32'h80000000, 0, 0, MODE_SPHERE), 0, '0});
    directed.push_back('{load_item(0, 0, 0, 0, 0, 0, -32'sh20000, -32'sh20000, -32'sh20000,
                                   MODE_BOX), 0, '0});
    directed.push_back('{load_item(0, 0, 0, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF,
                                   0, 0, 0, MODE_DEFAULT_SWEPT), 0, '0});
    directed.push_back('{load_item(32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000,
                                   32'h80000000, 32'h80000000, 32'h30000, 0, 0,
                                   MODE_SPHERE_SWEPT), 0, '0});
    directed.push_back('{load_item(0, 0, 0, 0, 0, 0, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF,
                                   MODE_SHAPE3), 0, '0});
    directed.push_back('{load_item(0, 0, 0, -32'sh100000, -32'sh100000, -32'sh100000,
                                   0, 0, 0, MODE_SHAPE3_SWEPT), 0, '0});
    directed.push_back('{load_item(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF,
                                   32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF,
                                   32'h7FFFFFFF, MODE_BOX_SWEPT), 0, '0});
    directed.push_back('{load_item(32'h80000000, 32'h80000000, 32'h80000000, 0, 0, 0,
                                   32'h80000000, 32'h80000000, 32'h80000000, MODE_BOX), 0, '0});
    directed.push_back('{load_item(32'h8000, 32'h8000, 32'h8000, 0, 0, 0, 0, 0, 0,
                                   MODE_DEFAULT), 0, '0});
    directed.push_back('{load_item(0, 0, 0, 0, 0, 0, 1, 0, 0, MODE_SPHERE), 0, '0});
    directed.push_back('{load_item(32'h9000, 0, 0, 0, 0, 0, 2, 0, 0, MODE_SPHERE), 0, '0});
    directed.push_back('{load_item(-32'sh10000, 0, 0, 0, 0, 0, 0, 0, 0, MODE_DEFAULT), 0, '0});
    directed.push_back('{load_item(0, 0, 0, 0, 0, 0, 0, 0, 0, MODE_BOX), 0, '0});
    // list full, dropped
    directed.push_back('{load_item(0, 0, 0, 0, 0, 0, 0, 0, 0, MODE_DEFAULT), 0, '0});
    directed.push_back('{ctl_item(CMD_QUERY, 4'd0), 0, '0});
    directed.push_back('{ctl_item(CMD_QUERY, 4'd15), 1, '{1'b0, 4'd15, 4'd0, 1'b1}});
    directed.push_back('{ctl_item(CMD_QUERY, 4'd4), 0, '0});
    directed.push_back('{ctl_item(CMD_UNUSED, 4'd7), 0, '0});
    directed.push_back('{ctl_item(CMD_QUERY, 4'd14), 0, '0});
    directed.push_back('{ctl_item(CMD_CLEAR, 4'd0), 0, '0});
    directed.push_back('{ctl_item(CMD_QUERY, 4'd3), 1, '{1'b0, 4'd3, 4'd0, 1'b1}});
    directed.push_back('{load_item(0, 0, 0, 0, 0, 0, 0, 0, 0, MODE_DEFAULT), 0, '0});
    directed.push_back('{ctl_item(CMD_QUERY, 4'd0), 1, '{1'b0, 4'd0, 4'd0, 1'b1}});

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    foreach (directed[i]) send_item(directed[i].item, directed[i].typed, directed[i].want);

    target = stim_count;
    for (int p = 0; p < 5; p++) begin
      set_time_step(dt_plan[p]);
      if (p == 4) idle_on = 1'b0;
      target += 14;
      while (stim_count < target) run_burst(p == 4);
    end

    s_tvalid <= 1'b0;
    while (pending_pairs.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (errors == 0) $display("PASS aabb_broad_phase_3d_swept");
    else $display("FAIL aabb_broad_phase_3d_swept");
    $finish;
  end

endmodule

// ----- filelist.f -----
sv/abps3_pkg.sv
sv/aabb_broad_phase_3d_swept.sv
sim/tb.sv
